[rtl/descriptor_slot_allocator_assert.svh]
// Assertion macros for the descriptor slot allocator
`ifndef DESCRIPTOR_SLOT_ALLOCATOR_ASSERT_SVH
`define DESCRIPTOR_SLOT_ALLOCATOR_ASSERT_SVH

// Same-cycle implication, disabled while reset is held
`define DSA_ASSERT_IMPL(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is held
`define DSA_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[rtl/dsa_pkg.sv]
// Shared types and constants of the descriptor slot allocator
`timescale 1ns / 1ps
package dsa_pkg;

    localparam int POOL_SLOTS  = 256;
    localparam int SLOT_W      = $clog2(POOL_SLOTS);
    localparam int SLOT_CNT_W  = $clog2(POOL_SLOTS + 1);
    localparam int CHUNK_BITS  = 32;
    localparam int POS_W       = $clog2(CHUNK_BITS);
    localparam int CHUNK_W     = SLOT_W - POS_W;
    localparam int ADDR_W      = 64;
    localparam int STRIDE_W    = 11;
    localparam int LIM_W       = SLOT_CNT_W + STRIDE_W;
    localparam int REM_W       = SLOT_W + STRIDE_W;
    localparam int PROD_W      = SLOT_W + STRIDE_W;
    localparam int DBIT_W      = $clog2(SLOT_W);
    localparam int CFG_IDX_W   = 3;
    localparam int CFG_DATA_W  = 64;

    typedef enum logic [1:0] {
        KIND_ALLOC       = 2'd0,
        KIND_FREE_HANDLE = 2'd1,
        KIND_FREE_INDEX  = 2'd2,
        KIND_FREE_ALL    = 2'd3
    } t_kind;

    typedef enum logic [1:0] {
        ST_OK     = 2'd0,
        ST_FULL   = 2'd1,
        ST_ABSENT = 2'd2,
        ST_RANGE  = 2'd3
    } t_status;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_HOST_BASE   = 3'd0,
        CFG_SHADER_BASE = 3'd1,
        CFG_SLOT_STRIDE = 3'd2,
        CFG_SHADER_EN   = 3'd3,
        CFG_SLOTS_USE   = 3'd4
    } t_cfg_reg;

    typedef enum logic [2:0] {
        S_IDLE   = 3'd0,
        S_DECODE = 3'd1,
        S_SEARCH = 3'd2,
        S_CHECK  = 3'd3,
        S_DIV    = 3'd4,
        S_MUL    = 3'd5,
        S_ADD    = 3'd6
    } t_state;

    typedef struct packed {
        logic    load;
        logic    sub;
        logic    div_init;
        logic    div_step;
        logic    srch_step;
        logic    take_slot;
        logic    mark;
        logic    clear_one;
        logic    clear_all;
        logic    mul;
        logic    emit;
        logic    emit_addr;
        t_status status;
    } t_dp_cmd;

    typedef struct packed {
        t_kind kind;
        logic  absent;
        logic  slot_range;
        logic  handle_range;
        logic  found;
        logic  chunk_last;
        logic  div_last;
    } t_dp_sts;

endpackage

[rtl/dsa_datapath.sv]
// Datapath: configuration, slot bitmaps, chunked search, divider and address unit
`timescale 1ns / 1ps
module dsa_datapath (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_we,
    input  logic [dsa_pkg::CFG_IDX_W-1:0]     i_cfg_idx,
    input  logic [dsa_pkg::CFG_DATA_W-1:0]    i_cfg_data,
    input  logic [1:0]                        i_kind,
    input  logic                              i_pool,
    input  logic [dsa_pkg::ADDR_W-1:0]        i_handle_in,
    input  logic [dsa_pkg::SLOT_W-1:0]        i_slot_in,
    input  dsa_pkg::t_dp_cmd                  i_cmd,
    output dsa_pkg::t_dp_sts                  o_sts,
    output logic                              o_result_valid,
    output logic [dsa_pkg::ADDR_W-1:0]        o_handle_out,
    output logic [dsa_pkg::SLOT_W-1:0]        o_slot_out,
    output logic [1:0]                        o_status
);

    logic [dsa_pkg::ADDR_W-1:0]      r_host_base;
    logic [dsa_pkg::ADDR_W-1:0]      r_shader_base;
    logic [dsa_pkg::STRIDE_W-1:0]    r_stride;
    logic                            r_shader_en;
    logic [dsa_pkg::SLOT_CNT_W-1:0]  r_slots;

    logic [dsa_pkg::POOL_SLOTS-1:0]  r_used [2];

    dsa_pkg::t_kind                  r_kind;
    logic                            r_pool;
    logic [dsa_pkg::ADDR_W-1:0]      r_handle;
    logic [dsa_pkg::SLOT_W-1:0]      r_slot;
    logic [dsa_pkg::ADDR_W-1:0]      r_diff;
    logic                            r_borrow;
    logic [dsa_pkg::REM_W-1:0]       r_rem;
    logic [dsa_pkg::DBIT_W-1:0]      r_dbit;
    logic [dsa_pkg::SLOT_W-1:0]      r_idx;
    logic [dsa_pkg::CHUNK_W-1:0]     r_chunk;
    logic [dsa_pkg::PROD_W-1:0]      r_prod;

    logic                            r_result_valid;
    logic [dsa_pkg::ADDR_W-1:0]      r_handle_out;
    logic [dsa_pkg::SLOT_W-1:0]      r_slot_out;
    dsa_pkg::t_status                r_status;

    logic [dsa_pkg::ADDR_W-1:0]      w_base;
    logic [dsa_pkg::SLOT_CNT_W-1:0]  w_n;
    logic [dsa_pkg::LIM_W-1:0]       w_lim;
    logic [dsa_pkg::CHUNK_BITS-1:0]  w_word;
    logic [dsa_pkg::CHUNK_BITS-1:0]  w_mask;
    logic [dsa_pkg::CHUNK_BITS-1:0]  w_free;
    logic [dsa_pkg::CHUNK_BITS-1:0]  w_low;
    logic [dsa_pkg::POS_W-1:0]       w_pos;
    logic [dsa_pkg::SLOT_W-1:0]      w_found_idx;
    logic [dsa_pkg::REM_W-1:0]       w_div_sh;
    logic                            w_div_ge;

    assign w_base = r_pool ? r_shader_base : r_host_base;
    assign w_n    = (r_slots > dsa_pkg::SLOT_CNT_W'(dsa_pkg::POOL_SLOTS))
                  ? dsa_pkg::SLOT_CNT_W'(dsa_pkg::POOL_SLOTS) : r_slots;
    assign w_lim  = dsa_pkg::LIM_W'(w_n) * dsa_pkg::LIM_W'(r_stride);

    assign w_word = r_used[r_pool][{r_chunk, {dsa_pkg::POS_W{1'b0}}} +: dsa_pkg::CHUNK_BITS];

    always_comb begin
        for (int j = 0; j < dsa_pkg::CHUNK_BITS; j++) begin
            w_mask[j] = ({1'b0, r_chunk, dsa_pkg::POS_W'(j)} < w_n);
        end
    end

    assign w_free = ~w_word & w_mask;
    assign w_low  = w_free & (~w_free + dsa_pkg::CHUNK_BITS'(1));

    always_comb begin
        w_pos = '0;
        for (int j = 0; j < dsa_pkg::CHUNK_BITS; j++) begin
            if (w_low[j]) begin
                w_pos = w_pos | dsa_pkg::POS_W'(j);
            end
        end
    end

    assign w_found_idx = {r_chunk, w_pos};

    assign w_div_sh = dsa_pkg::REM_W'(r_stride) << r_dbit;
    assign w_div_ge = (r_rem >= w_div_sh);

    assign o_sts.kind         = r_kind;
    assign o_sts.absent       = r_pool & ~r_shader_en;
    assign o_sts.slot_range   = ({1'b0, r_slot} >= w_n);
    assign o_sts.handle_range = r_borrow
                              | (r_stride == '0)
                              | (r_diff[dsa_pkg::ADDR_W-1:dsa_pkg::LIM_W] != '0)
                              | (r_diff[dsa_pkg::LIM_W-1:0] >= w_lim);
    assign o_sts.found        = |w_free;
    assign o_sts.chunk_last   = (r_chunk == '1);
    assign o_sts.div_last     = (r_dbit == '0);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_host_base   <= '0;
            r_shader_base <= '0;
            r_stride      <= dsa_pkg::STRIDE_W'(32);
            r_shader_en   <= 1'b0;
            r_slots       <= dsa_pkg::SLOT_CNT_W'(256);
        end else if (i_cfg_we) begin
            unique case (dsa_pkg::t_cfg_reg'(i_cfg_idx))
                dsa_pkg::CFG_HOST_BASE:   r_host_base   <= i_cfg_data;
                dsa_pkg::CFG_SHADER_BASE: r_shader_base <= i_cfg_data;
                dsa_pkg::CFG_SLOT_STRIDE: r_stride      <= i_cfg_data[dsa_pkg::STRIDE_W-1:0];
                dsa_pkg::CFG_SHADER_EN:   r_shader_en   <= i_cfg_data[0];
                dsa_pkg::CFG_SLOTS_USE:   r_slots       <= i_cfg_data[dsa_pkg::SLOT_CNT_W-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_used[0] <= '0;
            r_used[1] <= '0;
        end else if (i_cmd.clear_all) begin
            r_used[r_pool] <= '0;
        end else begin
            if (i_cmd.mark) begin
                r_used[r_pool][w_found_idx] <= 1'b1;
            end
            if (i_cmd.clear_one) begin
                r_used[r_pool][r_idx] <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_kind   <= dsa_pkg::t_kind'(i_kind);
            r_pool   <= i_pool;
            r_handle <= i_handle_in;
            r_slot   <= i_slot_in;
            r_chunk  <= '0;
        end
        if (i_cmd.srch_step) begin
            r_chunk <= r_chunk + dsa_pkg::CHUNK_W'(1);
        end
        if (i_cmd.sub) begin
            {r_borrow, r_diff} <= {1'b0, r_handle} - {1'b0, w_base};
        end
        if (i_cmd.div_init) begin
            r_rem  <= r_diff[dsa_pkg::REM_W-1:0];
            r_dbit <= dsa_pkg::DBIT_W'(dsa_pkg::SLOT_W - 1);
            r_idx  <= '0;
        end
        if (i_cmd.div_step) begin
            if (w_div_ge) begin
                r_rem <= r_rem - w_div_sh;
            end
            r_idx  <= {r_idx[dsa_pkg::SLOT_W-2:0], w_div_ge};
            r_dbit <= r_dbit - dsa_pkg::DBIT_W'(1);
        end
        if (i_cmd.take_slot) begin
            r_idx <= r_slot;
        end
        if (i_cmd.mark) begin
            r_idx <= w_found_idx;
        end
        if (i_cmd.mul) begin
            r_prod <= dsa_pkg::PROD_W'(r_idx) * dsa_pkg::PROD_W'(r_stride);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_result_valid <= 1'b0;
        end else begin
            r_result_valid <= i_cmd.emit;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.emit) begin
            if (i_cmd.emit_addr) begin
                r_handle_out <= w_base + dsa_pkg::ADDR_W'(r_prod);
                r_slot_out   <= r_idx;
                r_status     <= dsa_pkg::ST_OK;
            end else begin
                r_handle_out <= '0;
                r_slot_out   <= '0;
                r_status     <= i_cmd.status;
            end
        end
    end

    assign o_result_valid = r_result_valid;
    assign o_handle_out   = r_handle_out;
    assign o_slot_out     = r_slot_out;
    assign o_status       = r_status;

endmodule

[rtl/dsa_ctrl.sv]
// Controller state machine that sequences each request through the datapath
`timescale 1ns / 1ps
`include "descriptor_slot_allocator_assert.svh"
module dsa_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_start,
    input  dsa_pkg::t_dp_sts  i_sts,
    output dsa_pkg::t_dp_cmd  o_cmd,
    output logic              o_busy
);

    dsa_pkg::t_state   r_state;
    dsa_pkg::t_state   n_state;
    dsa_pkg::t_dp_cmd  w_cmd;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= dsa_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state      = r_state;
        w_cmd        = '0;
        w_cmd.status = dsa_pkg::ST_OK;
        unique case (r_state)
            dsa_pkg::S_IDLE: begin
                if (i_start) begin
                    w_cmd.load = 1'b1;
                    n_state    = dsa_pkg::S_DECODE;
                end
            end
            dsa_pkg::S_DECODE: begin
                if (i_sts.absent) begin
                    w_cmd.emit   = 1'b1;
                    w_cmd.status = dsa_pkg::ST_ABSENT;
                    n_state      = dsa_pkg::S_IDLE;
                end else begin
                    unique case (i_sts.kind)
                        dsa_pkg::KIND_ALLOC: begin
                            n_state = dsa_pkg::S_SEARCH;
                        end
                        dsa_pkg::KIND_FREE_HANDLE: begin
                            w_cmd.sub = 1'b1;
                            n_state   = dsa_pkg::S_CHECK;
                        end
                        dsa_pkg::KIND_FREE_INDEX: begin
                            if (i_sts.slot_range) begin
                                w_cmd.emit   = 1'b1;
                                w_cmd.status = dsa_pkg::ST_RANGE;
                                n_state      = dsa_pkg::S_IDLE;
                            end else begin
                                w_cmd.take_slot = 1'b1;
                                n_state         = dsa_pkg::S_MUL;
                            end
                        end
                        dsa_pkg::KIND_FREE_ALL: begin
                            w_cmd.clear_all = 1'b1;
                            w_cmd.emit      = 1'b1;
                            n_state         = dsa_pkg::S_IDLE;
                        end
                        default: begin
                            n_state = dsa_pkg::S_IDLE;
                        end
                    endcase
                end
            end
            dsa_pkg::S_SEARCH: begin
                if (i_sts.found) begin
                    w_cmd.mark = 1'b1;
                    n_state    = dsa_pkg::S_MUL;
                end else if (i_sts.chunk_last) begin
                    w_cmd.emit   = 1'b1;
                    w_cmd.status = dsa_pkg::ST_FULL;
                    n_state      = dsa_pkg::S_IDLE;
                end else begin
                    w_cmd.srch_step = 1'b1;
                end
            end
            dsa_pkg::S_CHECK: begin
                if (i_sts.handle_range) begin
                    w_cmd.emit   = 1'b1;
                    w_cmd.status = dsa_pkg::ST_RANGE;
                    n_state      = dsa_pkg::S_IDLE;
                end else begin
                    w_cmd.div_init = 1'b1;
                    n_state        = dsa_pkg::S_DIV;
                end
            end
            dsa_pkg::S_DIV: begin
                w_cmd.div_step = 1'b1;
                if (i_sts.div_last) begin
                    n_state = dsa_pkg::S_MUL;
                end
            end
            dsa_pkg::S_MUL: begin
                w_cmd.mul       = 1'b1;
                w_cmd.clear_one = (i_sts.kind != dsa_pkg::KIND_ALLOC);
                n_state         = dsa_pkg::S_ADD;
            end
            dsa_pkg::S_ADD: begin
                w_cmd.emit      = 1'b1;
                w_cmd.emit_addr = 1'b1;
                n_state         = dsa_pkg::S_IDLE;
            end
            default: begin
                n_state = dsa_pkg::S_IDLE;
            end
        endcase
    end

    assign o_cmd  = w_cmd;
    assign o_busy = (r_state != dsa_pkg::S_IDLE);

    `DSA_ASSERT_IMPL(a_emit_ends_request, w_cmd.emit, n_state == dsa_pkg::S_IDLE, "emit without return to idle")
    `DSA_ASSERT_NEXT(a_emit_single, w_cmd.emit, !w_cmd.emit, "two results for one request")
    `DSA_ASSERT_NEXT(a_start_decodes, i_start && (r_state == dsa_pkg::S_IDLE), r_state == dsa_pkg::S_DECODE, "accepted request not decoded")
    `DSA_ASSERT_IMPL(a_div_entry, r_state == dsa_pkg::S_DIV, $past(r_state) == dsa_pkg::S_CHECK || $past(r_state) == dsa_pkg::S_DIV, "divider entered without range check")

endmodule

[rtl/descriptor_slot_allocator.sv]
// Descriptor slot allocator top level: two bitmap pools with first-free allocation.
// Requests: raise i_start with i_kind, i_pool, i_handle_in and i_slot_in; the request
// is taken at a clock edge where i_start is high and o_busy is low.
// Configuration: i_cfg_we with i_cfg_idx and i_cfg_data writes one register per
// edge (0 host base, 1 shader base, 2 slot stride, 3 shader pool enable,
// 4 slots in use); write only while o_busy is low and no result is pending.
// Results: o_result_valid pulses for one cycle with o_handle_out, o_slot_out and
// o_status; the receiver must take it in that cycle and cannot stall the block.
// Sequence: free-all and every error decided at decode end at decode; a handle out
// of range ends at the range check; free by index goes through multiply and add;
// free by handle through subtract, range check, the bit-serial divider, multiply
// and add; allocation scans 32-slot chunks (1 to 8) before multiply and add, and a
// full pool ends after the last chunk. The result strobe rises in the same cycle
// as o_busy falls, and a new request can be taken in that same cycle.
// Reset: synchronous active low; every slot of both pools becomes free and the
// configuration registers, the controller state and the result strobe are reset.
`timescale 1ns / 1ps
module descriptor_slot_allocator (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_we,
    input  logic [dsa_pkg::CFG_IDX_W-1:0]     i_cfg_idx,
    input  logic [dsa_pkg::CFG_DATA_W-1:0]    i_cfg_data,
    input  logic                              i_start,
    output logic                              o_busy,
    input  logic [1:0]                        i_kind,
    input  logic                              i_pool,
    input  logic [dsa_pkg::ADDR_W-1:0]        i_handle_in,
    input  logic [dsa_pkg::SLOT_W-1:0]        i_slot_in,
    output logic                              o_result_valid,
    output logic [dsa_pkg::ADDR_W-1:0]        o_handle_out,
    output logic [dsa_pkg::SLOT_W-1:0]        o_slot_out,
    output logic [1:0]                        o_status
);

    dsa_pkg::t_dp_cmd  w_cmd;
    dsa_pkg::t_dp_sts  w_sts;

    dsa_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (i_start),
        .i_sts   (w_sts),
        .o_cmd   (w_cmd),
        .o_busy  (o_busy)
    );

    dsa_datapath u_datapath (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_idx      (i_cfg_idx),
        .i_cfg_data     (i_cfg_data),
        .i_kind         (i_kind),
        .i_pool         (i_pool),
        .i_handle_in    (i_handle_in),
        .i_slot_in      (i_slot_in),
        .i_cmd          (w_cmd),
        .o_sts          (w_sts),
        .o_result_valid (o_result_valid),
        .o_handle_out   (o_handle_out),
        .o_slot_out     (o_slot_out),
        .o_status       (o_status)
    );

endmodule

[sim/descriptor_slot_allocator_test.sv]
// Self-checking bench for the descriptor slot allocator with a bitmap scoreboard
`timescale 1ns / 1ps
module descriptor_slot_allocator_test;
    import dsa_pkg::*;

    localparam int CYCLE_LIMIT = 400000;
    localparam int PHASES      = 12;
    localparam int PHASE_ITEMS = 150;

    typedef struct {
        logic [ADDR_W-1:0] handle;
        logic [SLOT_W-1:0] slot;
        t_status           status;
    } t_slot_result;

    class slot_scoreboard;
        logic [ADDR_W-1:0]     base_addr [2];
        logic [STRIDE_W-1:0]   stride;
        logic                  shader_on;
        logic [SLOT_CNT_W-1:0] slot_limit;
        bit [POOL_SLOTS-1:0]   taken [2];
        t_slot_result          awaited [$];
        int                    fail_count;
        int                    requests;
        int                    status_seen [4];

        function new();
            base_addr[0] = '0;
            base_addr[1] = '0;
            stride       = 11'd32;
            shader_on    = 1'b0;
            slot_limit   = 9'd256;
            taken[0]     = '0;
            taken[1]     = '0;
            fail_count   = 0;
            requests     = 0;
            foreach (status_seen[i]) status_seen[i] = 0;
        endfunction

        function void set_register(t_cfg_reg idx, logic [CFG_DATA_W-1:0] data);
            case (idx)
                CFG_HOST_BASE:   base_addr[0] = data;
                CFG_SHADER_BASE: base_addr[1] = data;
                CFG_SLOT_STRIDE: stride       = data[STRIDE_W-1:0];
                CFG_SHADER_EN:   shader_on    = data[0];
                CFG_SLOTS_USE:   slot_limit   = data[SLOT_CNT_W-1:0];
                default: ;
            endcase
        endfunction

        function int managed();
            return (int'(slot_limit) < POOL_SLOTS) ? int'(slot_limit) : POOL_SLOTS;
        endfunction

        function int pick_taken(logic pool);
            int cand [$];
            for (int i = 0; i < managed(); i++)
                if (taken[pool][i]) cand = {cand, i};
            if (cand.size() == 0) return -1;
            return cand[$urandom_range(cand.size() - 1)];
        endfunction

        function void note_request(t_kind kind, logic pool, logic [ADDR_W-1:0] handle,
                                   logic [SLOT_W-1:0] slot);
            t_slot_result      r;
            int                n;
            int                idx;
            logic [ADDR_W-1:0] base;
            logic [ADDR_W-1:0] quot;
            r.handle = '0;
            r.slot   = '0;
            r.status = ST_OK;
            n        = managed();
            base     = base_addr[pool];
            idx      = -1;
            requests++;
            if (pool && !shader_on) begin
                r.status = ST_ABSENT;
            end else begin
                case (kind)
                    KIND_ALLOC: begin
                        for (int i = 0; i < n && idx < 0; i++)
                            if (!taken[pool][i]) idx = i;
                        if (idx < 0) begin
                            r.status = ST_FULL;
                        end else begin
                            taken[pool][idx] = 1'b1;
                            r.slot   = idx[SLOT_W-1:0];
                            r.handle = base + 64'(idx) * 64'(stride);
                        end
                    end
                    KIND_FREE_HANDLE: begin
                        if (handle < base || stride == '0) begin
                            r.status = ST_RANGE;
                        end else begin
                            quot = (handle - base) / 64'(stride);
                            if (quot >= 64'(n)) begin
                                r.status = ST_RANGE;
                            end else begin
                                idx = int'(quot);
                                taken[pool][idx] = 1'b0;
                                r.slot   = idx[SLOT_W-1:0];
                                r.handle = base + quot * 64'(stride);
                            end
                        end
                    end
                    KIND_FREE_INDEX: begin
                        if (int'(slot) >= n) begin
                            r.status = ST_RANGE;
                        end else begin
                            taken[pool][slot] = 1'b0;
                            r.slot   = slot;
                            r.handle = base + 64'(slot) * 64'(stride);
                        end
                    end
                    default: taken[pool] = '0;
                endcase
            end
            awaited = {awaited, r};
        endfunction

        task report_mismatch(string msg);
            fail_count++;
            $display("mismatch at %0t ns: %s", $time, msg);
        endtask

        task check_result(logic [ADDR_W-1:0] handle, logic [SLOT_W-1:0] slot,
                          logic [1:0] status);
            t_slot_result e;
            if (awaited.size() == 0) begin
                report_mismatch($sformatf("result with no request waiting: %h %0d %0d",
                                          handle, slot, status));
                return;
            end
            e = awaited.pop_front();
            if (handle !== e.handle)
                report_mismatch($sformatf("handle %h, wanted %h", handle, e.handle));
            if (slot !== e.slot)
                report_mismatch($sformatf("slot %0d, wanted %0d", slot, e.slot));
            if (status !== e.status)
                report_mismatch($sformatf("status %0d, wanted %0d", status, e.status));
            status_seen[int'(e.status)]++;
        endtask
    endclass

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  i_cfg_we;
    logic [CFG_IDX_W-1:0]  i_cfg_idx;
    logic [CFG_DATA_W-1:0] i_cfg_data;
    logic                  i_start;
    logic                  o_busy;
    logic [1:0]            i_kind;
    logic                  i_pool;
    logic [ADDR_W-1:0]     i_handle_in;
    logic [SLOT_W-1:0]     i_slot_in;
    logic                  o_result_valid;
    logic [ADDR_W-1:0]     o_handle_out;
    logic [SLOT_W-1:0]     o_slot_out;
    logic [1:0]            o_status;

    slot_scoreboard sb = new();
    int             cycles = 0;
    bit             no_idle = 1'b0;

    descriptor_slot_allocator i_dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_idx      (i_cfg_idx),
        .i_cfg_data     (i_cfg_data),
        .i_start        (i_start),
        .o_busy         (o_busy),
        .i_kind         (i_kind),
        .i_pool         (i_pool),
        .i_handle_in    (i_handle_in),
        .i_slot_in      (i_slot_in),
        .o_result_valid (o_result_valid),
        .o_handle_out   (o_handle_out),
        .o_slot_out     (o_slot_out),
        .o_status       (o_status)
    );

    always begin
        i_clk = 1'b0;
        #2;
        i_clk = 1'b1;
        #2;
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d results outstanding",
                     cycles, sb.awaited.size());
            $display("FAILURE");
            $finish;
        end else if (i_rst_n && o_result_valid) begin
            sb.check_result(o_handle_out, o_slot_out, o_status);
        end
    end

    task automatic send_request(t_kind kind, logic pool, logic [ADDR_W-1:0] handle,
                                logic [SLOT_W-1:0] slot);
        bit accepted;
        while (!no_idle && $urandom_range(99) < 31) begin
            i_start <= 1'b0;
            @(negedge i_clk);
        end
        i_start     <= 1'b1;
        i_kind      <= kind;
        i_pool      <= pool;
        i_handle_in <= handle;
        i_slot_in   <= slot;
        accepted = 1'b0;
        while (!accepted) begin
            @(posedge i_clk);
            if (!o_busy) begin
                accepted = 1'b1;
                sb.note_request(kind, pool, handle, slot);
            end
            @(negedge i_clk);
        end
    endtask

    task automatic wait_drained();
        i_start <= 1'b0;
        @(negedge i_clk);
        while (sb.awaited.size() != 0 || o_busy) @(negedge i_clk);
    endtask

    task automatic write_register(t_cfg_reg idx, logic [CFG_DATA_W-1:0] data);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= data;
        sb.set_register(idx, data);
        @(negedge i_clk);
    endtask

    task automatic apply_settings(logic [63:0] host_b, logic [63:0] shader_b,
                                  logic [63:0] stride, logic [63:0] shader_en,
                                  logic [63:0] slots);
        write_register(CFG_HOST_BASE, host_b);
        write_register(CFG_SHADER_BASE, shader_b);
        write_register(CFG_SLOT_STRIDE, stride);
        write_register(CFG_SHADER_EN, shader_en);
        write_register(CFG_SLOTS_USE, slots);
        i_cfg_we <= 1'b0;
        @(negedge i_clk);
    endtask

    function automatic logic [63:0] random_base();
        case ($urandom_range(3))
            0:       return '0;
            1:       return {$urandom, $urandom};
            2:       return 64'hFFFF_FFFF_FFFF_F000 + 64'($urandom_range(4095));
            default: return 64'($urandom);
        endcase
    endfunction

    task automatic random_request(int alloc_pct);
        int                roll;
        int                n;
        int                idx;
        logic              pool;
        logic [ADDR_W-1:0] base;
        logic [ADDR_W-1:0] step;
        logic [ADDR_W-1:0] handle;
        logic [SLOT_W-1:0] slot;
        t_kind             kind;
        roll   = $urandom_range(99);
        pool   = 1'($urandom_range(1));
        n      = sb.managed();
        base   = sb.base_addr[pool];
        step   = 64'(sb.stride);
        handle = {$urandom, $urandom};
        slot   = 8'($urandom_range(255));
        if (roll < alloc_pct)
            kind = KIND_ALLOC;
        else if (roll < alloc_pct + (100 - alloc_pct) * 45 / 100)
            kind = KIND_FREE_HANDLE;
        else if (roll < 98)
            kind = KIND_FREE_INDEX;
        else
            kind = KIND_FREE_ALL;
        if (kind == KIND_FREE_HANDLE) begin
            if ($urandom_range(99) < 75) begin
                idx = sb.pick_taken(pool);
                if (idx < 0 && n > 0) idx = $urandom_range(n - 1);
                if (idx >= 0) begin
                    handle = base + 64'(idx) * step;
                    if (sb.stride != '0)
                        handle = handle + 64'($urandom_range(int'(sb.stride) - 1));
                end
            end else begin
                case ($urandom_range(2))
                    0:       ;
                    1:       handle = base - 64'($urandom_range(1, 4096));
                    default: handle = base + 64'(n) * step + 64'($urandom_range(4096));
                endcase
            end
        end else if (kind == KIND_FREE_INDEX && n > 0 && $urandom_range(99) < 75) begin
            idx = sb.pick_taken(pool);
            if (idx < 0) idx = $urandom_range(n - 1);
            slot = idx[SLOT_W-1:0];
        end
        send_request(kind, pool, handle, slot);
    endtask

    initial begin
        int          alloc_pct;
        int          roll;
        logic [63:0] hb;
        logic [63:0] shb;
        logic [63:0] stride;
        logic [63:0] slots;
        i_rst_n     <= 1'b0;
        i_start     <= 1'b0;
        i_cfg_we    <= 1'b0;
        i_cfg_idx   <= CFG_HOST_BASE;
        i_cfg_data  <= '0;
        i_kind      <= KIND_ALLOC;
        i_pool      <= 1'b0;
        i_handle_in <= '0;
        i_slot_in   <= '0;
        repeat (5) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // settings straight out of reset
        send_request(KIND_ALLOC, 1'b0, '0, '0);
        send_request(KIND_ALLOC, 1'b1, '0, '0);
        wait_drained();

        hb  = 64'h0000_8000_0000_0000;
        shb = 64'hFFFF_FFFF_FFFF_FE00;
        apply_settings(hb, shb, 64'd1024, 64'd1, 64'd2);
        send_request(KIND_ALLOC, 1'b0, '0, '0);
        send_request(KIND_ALLOC, 1'b0, '0, '0);
        send_request(KIND_ALLOC, 1'b1, '0, '0);
        send_request(KIND_ALLOC, 1'b1, '0, '0);
        send_request(KIND_FREE_HANDLE, 1'b0, hb + 64'd2047, '0);
        send_request(KIND_FREE_HANDLE, 1'b0, hb - 64'd1, '0);
        send_request(KIND_FREE_HANDLE, 1'b0, hb + 64'd2048, '0);
        send_request(KIND_FREE_HANDLE, 1'b1, '1, '1);
        send_request(KIND_FREE_INDEX, 1'b0, '0, 8'd255);
        send_request(KIND_FREE_INDEX, 1'b0, '0, 8'd1);
        send_request(KIND_FREE_ALL, 1'b1, '1, '1);
        send_request(KIND_FREE_INDEX, 1'b1, '0, 8'd0);
        wait_drained();

        apply_settings(hb, shb, 64'd0, 64'd0, 64'd0);
        send_request(KIND_ALLOC, 1'b0, '0, '0);
        send_request(KIND_ALLOC, 1'b1, '0, '0);
        send_request(KIND_FREE_INDEX, 1'b1, '0, 8'd0);
        send_request(KIND_FREE_HANDLE, 1'b0, hb, '0);
        wait_drained();

        apply_settings('0, shb, 64'd0, 64'd1, 64'd511);
        send_request(KIND_ALLOC, 1'b0, '0, '0);
        send_request(KIND_ALLOC, 1'b0, '0, '0);
        send_request(KIND_FREE_HANDLE, 1'b0, 64'h40, '0);
        send_request(KIND_FREE_INDEX, 1'b0, '0, 8'd255);
        send_request(KIND_FREE_ALL, 1'b0, '0, '0);

        for (int ph = 0; ph < PHASES; ph++) begin
            hb     = random_base();
            shb    = random_base();
            stride = 64'($urandom_range(1, 1024));
            roll   = $urandom_range(19);
            if (roll == 0) stride = 64'd0;
            else if (roll == 1) stride = 64'd1;
            else if (roll == 2) stride = 64'd1024;
            roll = $urandom_range(19);
            if (roll < 4) slots = 64'd256;
            else if (roll == 4) slots = 64'($urandom_range(257, 511));
            else if (roll == 5) slots = 64'd0;
            else slots = 64'($urandom_range(1, 24));
            if (ph == 0) begin
                hb = '0; shb = '1; stride = 64'd1; slots = 64'd256;
            end else if (ph == 1) begin
                hb = 64'hFFFF_FFFF_FFFF_0000; stride = 64'd1024; slots = 64'd1;
            end
            wait_drained();
            apply_settings(hb, shb, stride, 64'(ph < 2 || $urandom_range(3) != 0), slots);
            no_idle   = (ph == 5);
            alloc_pct = $urandom_range(40, 90);
            for (int k = 0; k < PHASE_ITEMS; k++) begin
                if ($urandom_range(199) == 0) wait_drained();
                random_request(alloc_pct);
            end
        end

        wait_drained();
        repeat (20) @(negedge i_clk);
        if (sb.awaited.size() != 0)
            sb.report_mismatch($sformatf("%0d results never arrived", sb.awaited.size()));
        $display("covered %0d requests over %0d random setting phases plus directed corners",
                 sb.requests, PHASES);
        $display("statuses seen: ok %0d, full %0d, shader absent %0d, out of range %0d",
                 sb.status_seen[ST_OK], sb.status_seen[ST_FULL],
                 sb.status_seen[ST_ABSENT], sb.status_seen[ST_RANGE]);
        if (sb.fail_count == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule
